[hdl/mmh64_pkg.sv]
// ----------------------------------------------------------------------------
// mmh64_pkg
// Shared constants, types and helpers for the MurmurHash64A stream hasher.
// ----------------------------------------------------------------------------
package mmh64_pkg;

   localparam int WORD_W  = 64;
   localparam int COUNT_W = 4;
   localparam int LEN_W   = 32;
   localparam int HALF_W  = 32;

   localparam logic [WORD_W-1:0] MIX_MUL       = 64'hc6a4a7935bd1e995;
   localparam int                MIX_SHIFT     = 47;
   localparam logic [WORD_W-1:0] SEED_AT_RESET = 64'd7;
   localparam logic [COUNT_W-1:0] FULL_COUNT   = 4'd8;

   // one 32x32 partial product per cycle
   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LO,
      MUL_X1,
      MUL_X2
   } mul_op_type;

   typedef enum logic [2:0] {
      SRC_LEN,
      SRC_WORD,
      SRC_MIXK,
      SRC_HASH,
      SRC_FIN
   } src_sel_type;

   typedef enum logic [2:0] {
      H_KEEP,
      H_SEED,
      H_XK,
      H_ACC,
      H_PART
   } hash_op_type;

   typedef enum logic [1:0] {
      WORD_EMPTY,
      WORD_PART,
      WORD_FULL
   } word_kind_type;

   typedef struct packed {
      logic        capture;
      mul_op_type  mul;
      src_sel_type src;
      hash_op_type hop;
      logic        emit;
   } dp_cmd_type;

   typedef struct packed {
      logic          first;
      logic          last;
      word_kind_type kind;
      logic          rsp_busy;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_LEN_LO,
      S_LEN_X1,
      S_LEN_X2,
      S_SEED,
      S_K_LO,
      S_K_X1,
      S_K_X2,
      S_M_LO,
      S_M_X1,
      S_M_X2,
      S_FOLD,
      S_PART,
      S_H_LO,
      S_H_X1,
      S_H_X2,
      S_H_SET,
      S_F_LO,
      S_F_X1,
      S_F_X2,
      S_EMIT
   } ctrl_state_type;

   function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] x);
      return x ^ (x >> MIX_SHIFT);
   endfunction

endpackage

[hdl/mmh64_ifs.sv]
// ----------------------------------------------------------------------------
// mmh64 channel interfaces
// Valid/ready channels for message words, hash results and the seed write.
// ----------------------------------------------------------------------------
interface mmh64_req_if import mmh64_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   data_word;
   logic [COUNT_W-1:0]  byte_count;
   logic                first_word;
   logic                last_word;
   logic [LEN_W-1:0]    message_length;

   modport source (output valid, data_word, byte_count, first_word, last_word,
                   message_length, input ready);
   modport sink (input valid, data_word, byte_count, first_word, last_word,
                 message_length, output ready);
endinterface

interface mmh64_rsp_if import mmh64_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

interface mmh64_csr_if import mmh64_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_seed;

   modport source (output valid, hash_seed, input ready);
   modport sink (input valid, hash_seed, output ready);
endinterface

[hdl/murmur64a_stream_hash.sv]
// ----------------------------------------------------------------------------
// murmur64a_stream_hash
// MurmurHash64A over a stream of little-endian 64-bit message words.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake       payload
//  req_if   in   valid / ready   data_word, byte_count, first_word,
//                                last_word, message_length
//  rsp_if   out  valid / ready   hash_value (one item per last_word)
//  csr_if   in   valid / ready   hash_seed (always ready)
//
//  One item at a time. All 64-bit products by M go through a single 32x32
//  multiplier, one partial product at a time; that multiplier sets the rate.
//  Per item: capture; on first_word, length*M folded into the seed; a full
//  word takes k*M, xor-shift, *M, fold and hash*M, a partial word a masked
//  fold and hash*M; on last_word, finalize and emit (after any rsp_if wait).
//  Synchronous reset: seed back to 7, running hash to 0, no result pending.
//  A new item is taken while a finished hash still waits on rsp_if; a second
//  hash waits in the final step until the result register is free.
//
module murmur64a_stream_hash import mmh64_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   mmh64_req_if.sink    req_if,
   mmh64_rsp_if.source  rsp_if,
   mmh64_csr_if.sink    csr_if
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          req_ready;

   // seed register is written whenever offered
   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;

   mmh64_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   mmh64_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_data_word      (req_if.data_word),
      .req_byte_count     (req_if.byte_count),
      .req_first_word     (req_if.first_word),
      .req_last_word      (req_if.last_word),
      .req_message_length (req_if.message_length),
      .csr_valid          (csr_if.valid),
      .csr_hash_seed      (csr_if.hash_seed),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_hash_value     (rsp_if.hash_value)
   );

endmodule

[hdl/mmh64_datapath.sv]
// ----------------------------------------------------------------------------
// mmh64_datapath
// Item capture, shared 32x32 multiplier, running hash, seed and result regs.
// ----------------------------------------------------------------------------
module mmh64_datapath import mmh64_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic [COUNT_W-1:0]  req_byte_count,
   input  logic                req_first_word,
   input  logic                req_last_word,
   input  logic [LEN_W-1:0]    req_message_length,
   input  logic                csr_valid,
   input  logic [WORD_W-1:0]   csr_hash_seed,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_hash_value
);

   logic [WORD_W-1:0]  word_ff, word_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               first_ff, first_in;
   logic               last_ff, last_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [WORD_W-1:0]  opnd_ff, opnd_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic [WORD_W-1:0]  hash_ff, hash_in;
   logic [WORD_W-1:0]  seed_ff, seed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_hash_ff, rsp_hash_in;

   logic [WORD_W-1:0] src_val;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic [WORD_W-1:0] prod;
   logic [WORD_W-1:0] masked_word;

   always_comb begin
      case (cmd.src)
         SRC_LEN:  src_val = {{(WORD_W-LEN_W){1'b0}}, len_ff};
         SRC_WORD: src_val = word_ff;
         SRC_MIXK: src_val = xor_shift(acc_ff);
         SRC_HASH: src_val = hash_ff;
         SRC_FIN:  src_val = xor_shift(hash_ff);
         default:  src_val = '0;
      endcase
   end

   // low 64 bits of x*M from three partial products
   always_comb begin
      case (cmd.mul)
         MUL_LO: begin
            mul_a = src_val[HALF_W-1:0];
            mul_b = MIX_MUL[HALF_W-1:0];
         end
         MUL_X1: begin
            mul_a = opnd_ff[WORD_W-1:HALF_W];
            mul_b = MIX_MUL[HALF_W-1:0];
         end
         MUL_X2: begin
            mul_a = opnd_ff[HALF_W-1:0];
            mul_b = MIX_MUL[WORD_W-1:HALF_W];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked_word[8*i +: 8] = (COUNT_W'(i) < count_ff) ? word_ff[8*i +: 8] : 8'h00;
      end
   end

   always_comb begin
      word_in      = word_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      opnd_in      = opnd_ff;
      acc_in       = acc_ff;
      hash_in      = hash_ff;
      seed_in      = seed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;

      if (cmd.capture) begin
         word_in  = req_data_word;
         count_in = req_byte_count;
         first_in = req_first_word;
         last_in  = req_last_word;
         len_in   = req_message_length;
      end

      case (cmd.mul)
         MUL_LO: begin
            acc_in  = prod;
            opnd_in = src_val;
         end
         MUL_X1, MUL_X2: begin
            acc_in = {acc_ff[WORD_W-1:HALF_W] + prod[HALF_W-1:0], acc_ff[HALF_W-1:0]};
         end
         default: ;
      endcase

      case (cmd.hop)
         H_SEED:  hash_in = seed_ff ^ acc_ff;
         H_XK:    hash_in = hash_ff ^ acc_ff;
         H_ACC:   hash_in = acc_ff;
         H_PART:  hash_in = hash_ff ^ masked_word;
         default: ;
      endcase

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in  = xor_shift(acc_ff);
      end

      if (csr_valid) begin
         seed_in = csr_hash_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         seed_ff      <= SEED_AT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      count_ff    <= count_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      len_ff      <= len_in;
      opnd_ff     <= opnd_in;
      acc_ff      <= acc_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   always_comb begin
      status.first    = first_ff;
      status.last     = last_ff;
      status.rsp_busy = rsp_valid_ff && !rsp_ready;
      if (count_ff >= FULL_COUNT) begin
         status.kind = WORD_FULL;
      end else if (count_ff == '0) begin
         status.kind = WORD_EMPTY;
      end else begin
         status.kind = WORD_PART;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

[hdl/mmh64_ctrl.sv]
// ----------------------------------------------------------------------------
// mmh64_ctrl
// Datapath sequencer: one micro-step per cycle save for idle and emit waits.
// ----------------------------------------------------------------------------
module mmh64_ctrl import mmh64_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   function automatic ctrl_state_type word_dispatch(input dp_status_type st);
      ctrl_state_type nxt;
      case (st.kind)
         WORD_FULL: nxt = S_K_LO;
         WORD_PART: nxt = S_PART;
         default:   nxt = st.last ? S_F_LO : S_IDLE;
      endcase
      return nxt;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.mul     = MUL_NONE;
      cmd.src     = SRC_LEN;
      cmd.hop     = H_KEEP;
      cmd.emit    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = status.first ? S_LEN_LO : word_dispatch(status);
         end
         S_LEN_LO: begin
            cmd.mul  = MUL_LO;
            cmd.src  = SRC_LEN;
            state_in = S_LEN_X1;
         end
         S_LEN_X1: begin
            cmd.mul  = MUL_X1;
            state_in = S_LEN_X2;
         end
         S_LEN_X2: begin
            cmd.mul  = MUL_X2;
            state_in = S_SEED;
         end
         S_SEED: begin
            cmd.hop  = H_SEED;
            state_in = word_dispatch(status);
         end
         S_K_LO: begin
            cmd.mul  = MUL_LO;
            cmd.src  = SRC_WORD;
            state_in = S_K_X1;
         end
         S_K_X1: begin
            cmd.mul  = MUL_X1;
            state_in = S_K_X2;
         end
         S_K_X2: begin
            cmd.mul  = MUL_X2;
            state_in = S_M_LO;
         end
         S_M_LO: begin
            cmd.mul  = MUL_LO;
            cmd.src  = SRC_MIXK;
            state_in = S_M_X1;
         end
         S_M_X1: begin
            cmd.mul  = MUL_X1;
            state_in = S_M_X2;
         end
         S_M_X2: begin
            cmd.mul  = MUL_X2;
            state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.hop  = H_XK;
            state_in = S_H_LO;
         end
         S_PART: begin
            cmd.hop  = H_PART;
            state_in = S_H_LO;
         end
         S_H_LO: begin
            cmd.mul  = MUL_LO;
            cmd.src  = SRC_HASH;
            state_in = S_H_X1;
         end
         S_H_X1: begin
            cmd.mul  = MUL_X1;
            state_in = S_H_X2;
         end
         S_H_X2: begin
            cmd.mul  = MUL_X2;
            state_in = S_H_SET;
         end
         S_H_SET: begin
            cmd.hop  = H_ACC;
            state_in = status.last ? S_F_LO : S_IDLE;
         end
         S_F_LO: begin
            cmd.mul  = MUL_LO;
            cmd.src  = SRC_FIN;
            state_in = S_F_X1;
         end
         S_F_X1: begin
            cmd.mul  = MUL_X1;
            state_in = S_F_X2;
         end
         S_F_X2: begin
            cmd.mul  = MUL_X2;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold the finished hash until the result register frees up
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MurmurHash64A stream hasher. A bit-true hash
// model predicts every emitted hash. Directed edge messages come first.
// Random messages follow under several seeds and idle patterns on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;
   import mmh64_pkg::*;

   localparam int          CLK_HALF      = 10;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   // margin for the worst item inside the block and a pending result
   localparam int          SETTLE_CYCLES = 64;
   localparam int          MAX_REPORTS   = 10;

   typedef struct {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;
      logic               first;
      logic               last;
      logic [LEN_W-1:0]   length;
   } msg_item_type;

   logic clock;
   logic reset;

   mmh64_req_if req_if ();
   mmh64_rsp_if rsp_if ();
   mmh64_csr_if csr_if ();

   murmur64a_stream_hash u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // hash model state and the hashes still owed by the block
   logic [WORD_W-1:0] seed_model;
   logic [WORD_W-1:0] running_hash_model;
   logic [WORD_W-1:0] hash_expect_q[$];

   int          req_idle_pct;
   int          rsp_stall_pct;
   int          error_count;
   int          report_count;
   int unsigned cycle_count;

   // ---------------------------------------------------------------------
   // clock and run limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d hashes outstanding",
                  cycle_count, hash_expect_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // hash model
   // ---------------------------------------------------------------------
   // full-word scramble: k*M, xor-shift, k*M
   function automatic logic [WORD_W-1:0] scramble_word(input logic [WORD_W-1:0] k);
      logic [WORD_W-1:0] t;
      t = k * MIX_MUL;
      t = t ^ (t >> MIX_SHIFT);
      t = t * MIX_MUL;
      return t;
   endfunction

   function automatic logic [WORD_W-1:0] finalize_hash(input logic [WORD_W-1:0] h);
      logic [WORD_W-1:0] t;
      t = h ^ (h >> MIX_SHIFT);
      t = t * MIX_MUL;
      t = t ^ (t >> MIX_SHIFT);
      return t;
   endfunction

   // fold one accepted item into the model; a last item owes one hash
   task automatic absorb_item(input msg_item_type it);
      logic [WORD_W-1:0] h;
      logic [WORD_W-1:0] mask;
      h = running_hash_model;
      // first mark reloads from seed and length, otherwise keep running
      if (it.first)
         h = seed_model ^ (WORD_W'(it.length) * MIX_MUL);
      if (it.count >= FULL_COUNT) begin
         // counts above eight act as a full word
         h = h ^ scramble_word(it.word);
         h = h * MIX_MUL;
      end else if (it.count != '0) begin
         // tail bytes: bytes past the count are masked off
         mask = (64'd1 << (8 * it.count)) - 64'd1;
         h = h ^ (it.word & mask);
         h = h * MIX_MUL;
      end
      // running hash stays unfinalized after an emission
      running_hash_model = h;
      if (it.last)
         hash_expect_q.push_back(finalize_hash(h));
   endtask

   // ---------------------------------------------------------------------
   // result side: random stalls, compare each hash with the oldest owed
   // ---------------------------------------------------------------------
   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (hash_expect_q.size() == 0) begin
            error_count++;
            if (report_count < MAX_REPORTS) begin
               report_count++;
               $display("unexpected hash item %h", rsp_if.hash_value);
            end
         end else begin
            if (rsp_if.hash_value !== hash_expect_q[0]) begin
               error_count++;
               if (report_count < MAX_REPORTS) begin
                  report_count++;
                  $display("hash mismatch: expected %h actual %h",
                           hash_expect_q[0], rsp_if.hash_value);
               end
            end
            void'(hash_expect_q.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------------
   // message side
   // ---------------------------------------------------------------------
   function automatic msg_item_type mk_item(input logic [WORD_W-1:0] word,
                                            input logic [COUNT_W-1:0] count,
                                            input logic first, input logic last,
                                            input logic [LEN_W-1:0] length);
      msg_item_type it;
      it.word   = word;
      it.count  = count;
      it.first  = first;
      it.last   = last;
      it.length = length;
      return it;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // one item: optional idle gap, then hold until the block takes it
   task automatic send_item(input msg_item_type it);
      bit taken;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.data_word      <= it.word;
      req_if.byte_count     <= it.count;
      req_if.first_word     <= it.first;
      req_if.last_word      <= it.last;
      req_if.message_length <= it.length;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_if.ready;
      end
      absorb_item(it);
   endtask

   // drop valid, let every owed hash come back, then let a trailing
   // resultless item finish inside the block
   task automatic settle_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (hash_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [WORD_W-1:0] value);
      bit taken;
      @(negedge clock);
      csr_if.valid     <= 1'b1;
      csr_if.hash_seed <= value;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = csr_if.ready;
      end
      seed_model = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // well-formed message of nbytes; corrupt bends flags, counts or length
   task automatic send_message(input int nbytes, input bit corrupt, inout int sent);
      int           nfull;
      int           rem;
      int           n_items;
      msg_item_type it;
      nfull   = nbytes / 8;
      rem     = nbytes % 8;
      n_items = nfull + ((rem != 0) ? 1 : 0);
      if (n_items == 0)
         n_items = 1;
      for (int i = 0; i < n_items; i++) begin
         it.word  = rand_word();
         it.count = (i < nfull) ? FULL_COUNT : COUNT_W'(rem);
         it.first = (i == 0);
         it.last  = (i == n_items - 1);
         // length is only sampled on the first item; junk elsewhere
         it.length = (i == 0) ? LEN_W'(nbytes) : LEN_W'($urandom());
         if (corrupt) begin
            if ($urandom_range(3) == 0) it.first  = ~it.first;
            if ($urandom_range(3) == 0) it.last   = ~it.last;
            if ($urandom_range(3) == 0) it.count  = COUNT_W'($urandom_range(15));
            if ($urandom_range(3) == 0) it.length = LEN_W'($urandom());
         end
         send_item(it);
         sent++;
      end
   endtask

   task automatic run_random_traffic(input int n_target);
      int sent;
      int pick;
      int nbytes;
      sent = 0;
      while (sent < n_target) begin
         pick = $urandom_range(99);
         // mostly short messages, now and then a long one
         nbytes = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(40);
         if (pick < 75) begin
            send_message(nbytes, 1'b0, sent);
         end else if (pick < 90) begin
            send_message(nbytes, 1'b1, sent);
         end else begin
            send_item(mk_item(rand_word(), COUNT_W'($urandom_range(15)),
                              1'($urandom()), 1'($urandom()), LEN_W'($urandom())));
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // edge messages at the reset seed, no idling
   task automatic test_edge_messages();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      // no first mark straight out of reset: continues from zero
      send_item(mk_item(rand_word(), FULL_COUNT, 1'b0, 1'b1, '0));
      // empty messages, length field at both extremes
      send_item(mk_item(rand_word(), 4'd0, 1'b1, 1'b1, 32'd0));
      send_item(mk_item(rand_word(), 4'd0, 1'b1, 1'b1, 32'hffff_ffff));
      // single tail words with junk above the count
      send_item(mk_item({64{1'b1}}, 4'd1, 1'b1, 1'b1, 32'd1));
      send_item(mk_item({64{1'b1}}, 4'd7, 1'b1, 1'b1, 32'd7));
      // single full words at the data extremes
      send_item(mk_item({64{1'b0}}, FULL_COUNT, 1'b1, 1'b1, 32'd8));
      send_item(mk_item({64{1'b1}}, FULL_COUNT, 1'b1, 1'b1, 32'd8));
      // nine bytes: full word plus one tail byte
      send_item(mk_item(rand_word(), FULL_COUNT, 1'b1, 1'b0, 32'd9));
      send_item(mk_item(rand_word(), 4'd1, 1'b0, 1'b1, 32'hffff_ffff));
      // counts above eight behave as full words
      send_item(mk_item(rand_word(), 4'd9, 1'b1, 1'b1, 32'd8));
      send_item(mk_item(rand_word(), 4'd15, 1'b1, 1'b1, 32'd8));
      // zero-byte and partial words in mid message, length mismatch
      send_item(mk_item(rand_word(), 4'd0, 1'b1, 1'b0, 32'd100));
      send_item(mk_item(rand_word(), 4'd3, 1'b0, 1'b0, '0));
      send_item(mk_item(rand_word(), FULL_COUNT, 1'b0, 1'b1, '0));
      // carry on after an emission without a first mark
      send_item(mk_item(rand_word(), FULL_COUNT, 1'b0, 1'b1, '0));
      // a new first mark cuts an open message short
      send_item(mk_item(rand_word(), FULL_COUNT, 1'b1, 1'b0, 32'd12));
      send_item(mk_item(rand_word(), 4'd4, 1'b1, 1'b1, 32'd4));
      // sixteen bytes of alternating bits
      send_item(mk_item(64'haaaa_aaaa_aaaa_aaaa, FULL_COUNT, 1'b1, 1'b0, 32'd16));
      send_item(mk_item(64'h5555_5555_5555_5555, FULL_COUNT, 1'b0, 1'b1, 32'd16));
   endtask

   task automatic test_full_rate();
      settle_idle();
      write_seed('0);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      run_random_traffic(400);
   endtask

   task automatic test_sender_gaps();
      settle_idle();
      write_seed({WORD_W{1'b1}});
      req_idle_pct  = 77;
      rsp_stall_pct = 0;
      run_random_traffic(400);
   endtask

   task automatic test_receiver_stalls();
      settle_idle();
      write_seed(rand_word());
      req_idle_pct  = 0;
      rsp_stall_pct = 77;
      run_random_traffic(400);
   endtask

   task automatic test_mixed_backpressure();
      settle_idle();
      write_seed(rand_word());
      req_idle_pct  = 33;
      rsp_stall_pct = 33;
      run_random_traffic(450);
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.data_word      = '0;
      req_if.byte_count     = '0;
      req_if.first_word     = 1'b0;
      req_if.last_word      = 1'b0;
      req_if.message_length = '0;
      rsp_if.ready          = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.hash_seed      = '0;
      req_idle_pct          = 0;
      rsp_stall_pct         = 0;
      error_count           = 0;
      report_count          = 0;
      seed_model            = SEED_AT_RESET;
      running_hash_model    = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_messages();
      test_full_rate();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_backpressure();
      settle_idle();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/mmh64_pkg.sv
hdl/mmh64_ifs.sv
hdl/mmh64_datapath.sv
hdl/mmh64_ctrl.sv
hdl/murmur64a_stream_hash.sv
sim/tb_top.sv
